FILE: rtl/pcpa_pkg.sv
// ----------------------------------------------------------------------------
// pcpa_pkg: shared definitions of the per-CPU page free list allocator
// Field widths, request and status codes, and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package pcpa_pkg;

	localparam int ADDR_W     = 34;
	localparam int CPU_W      = 3;
	localparam int PAGE_SHIFT = 12;
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 64;

	typedef logic [ADDR_W-1:0] addr_t;

	// Request kinds.
	localparam logic KIND_FREE  = 1'b0;
	localparam logic KIND_ALLOC = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_FREED     = 2'd0,
		ST_ALLOCATED = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_REJECTED  = 2'd3
	} status_t;

	// Configuration register indexes, taken from paddr[4:3].
	localparam logic [1:0] REG_TABLE_BASE  = 2'd0;
	localparam logic [1:0] REG_LOWER_LIMIT = 2'd1;
	localparam logic [1:0] REG_UPPER_LIMIT = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/pcpa_if.sv
// ----------------------------------------------------------------------------
// pcpa_if: request and response channels of the page allocator
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcpa_req_if;
	import pcpa_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [CPU_W-1:0]  cpu;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output kind, output cpu, output address, input ready);
	modport sink   (input valid, input kind, input cpu, input address, output ready);
endinterface

interface pcpa_rsp_if;
	import pcpa_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [ADDR_W-1:0] page_address;
	logic [CPU_W-1:0]  source_list;

	modport source (output valid, output status, output page_address, output source_list,
		input ready);
	modport sink   (input valid, input status, input page_address, input source_list,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/pcpa_ram.sv
// ----------------------------------------------------------------------------
// pcpa_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpa_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 32768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/per_cpu_page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator: page-frame allocator with per-CPU lists
// LIFO free list per CPU linked through a next-page RAM, with stealing.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the req channel (kind, cpu, address) and every
// request produces exactly one response transaction on the rsp channel
// (status, page_address, source_list). A free pushes the page onto the list of
// the requesting CPU; an allocate pops the requester's list, or the
// lowest-numbered non-empty list when the requester's own list is empty.
// Registers table_base, free_lower_limit and free_upper_limit sit at APB byte
// addresses 0, 8, 16; write them only while the block is idle (not enforced).
//
// Timing. A free is checked and committed in the cycle it is accepted, so its
// response is valid in the next cycle; a new request can be taken every cycle
// while the receiver takes each response. An allocate issues a read of the
// next-page RAM at the popped head in its accept cycle and writes the new head
// in the following cycle (S_POP), once the RAM data has arrived; its response
// is registered at the end of S_POP, and no request is accepted during S_POP.
//
// Reset clears all list-valid bits (all lists empty), restores the register
// defaults and empties the response register. The next-page RAM is not cleared.
// When the receiver stalls, the response is held in the output register and no
// new request is accepted until it has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module per_cpu_page_free_list_allocator #(
	parameter int CPU_COUNT  = 8,
	parameter int PAGE_COUNT = 32768
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	pcpa_req_if.sink                     req,
	pcpa_rsp_if.source                   rsp,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [pcpa_pkg::PADDR_W-1:0] paddr,
	input  wire logic [pcpa_pkg::PDATA_W-1:0] pwdata,
	output      logic [pcpa_pkg::PDATA_W-1:0] prdata,
	output      logic                    pready
);
	import pcpa_pkg::*;

	localparam int IDX_W  = $clog2(PAGE_COUNT);
	localparam int LIST_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam int PG_W   = ADDR_W - PAGE_SHIFT;

	typedef enum logic {S_IDLE, S_POP} state_t;

	// ------------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------------
	addr_t table_base_q;
	addr_t lower_limit_q;
	addr_t upper_limit_q;
	logic  cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_base_q  <= 34'h0_8000_0000;
			lower_limit_q <= 34'h0_8000_0000;
			upper_limit_q <= 34'h0_8800_0000;
		end else if (cfg_write) begin
			unique case (paddr[4:3])
				REG_TABLE_BASE:  table_base_q  <= pwdata[ADDR_W-1:0];
				REG_LOWER_LIMIT: lower_limit_q <= pwdata[ADDR_W-1:0];
				REG_UPPER_LIMIT: upper_limit_q <= pwdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_TABLE_BASE:  prdata = PDATA_W'(table_base_q);
			REG_LOWER_LIMIT: prdata = PDATA_W'(lower_limit_q);
			REG_UPPER_LIMIT: prdata = PDATA_W'(upper_limit_q);
			default:         prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------------
	// List state: heads and non-empty bits per CPU list.
	// ------------------------------------------------------------------------
	state_t            state_q;
	logic [IDX_W-1:0]  heads_q [CPU_COUNT];
	logic [CPU_COUNT-1:0] nonempty_q;
	logic [LIST_W-1:0] pop_list_q;
	logic [IDX_W-1:0]  pop_idx_q;

	logic              rsp_valid_q;
	status_t           rsp_status_q;
	addr_t             rsp_addr_q;
	logic [CPU_W-1:0]  rsp_list_q;

	logic              accept;
	logic              cpu_valid;
	logic [LIST_W-1:0] cpu_list;
	logic              any_nonempty;
	logic [LIST_W-1:0] found;
	logic [LIST_W-1:0] sel_list;
	logic [IDX_W-1:0]  sel_head;
	logic              sel_nonempty;

	logic              free_ok;
	addr_t             offset;
	logic [PG_W-1:0]   page_num;
	logic              do_free;
	logic              do_pop;

	logic [IDX_W:0]    ram_rdata;

	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign cpu_valid = {1'b0, req.cpu} < (CPU_W + 1)'(CPU_COUNT);
	assign cpu_list  = req.cpu[LIST_W-1:0];

	// Stealing order: the requester's own list first, else the lowest-numbered
	// non-empty list.
	always_comb begin
		found = '0;
		for (int i = CPU_COUNT - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				found = LIST_W'(i);
			end
		end
		if (cpu_valid && nonempty_q[cpu_list]) begin
			found = cpu_list;
		end
	end
	assign any_nonempty = |nonempty_q;

	// One head read per cycle, addressed by the request kind.
	assign sel_list     = (req.kind == KIND_ALLOC) ? found : cpu_list;
	assign sel_head     = heads_q[sel_list];
	assign sel_nonempty = nonempty_q[sel_list];

	// Free checks: alignment, window limits, table bounds and CPU number.
	assign offset   = req.address - table_base_q;
	assign page_num = offset[ADDR_W-1:PAGE_SHIFT];
	assign free_ok  = (req.address[PAGE_SHIFT-1:0] == '0)
		&& (req.address >= lower_limit_q)
		&& (req.address < upper_limit_q)
		&& (req.address >= table_base_q)
		&& cpu_valid
		&& (page_num < PG_W'(PAGE_COUNT));

	assign do_free = accept && (req.kind == KIND_FREE) && free_ok;
	assign do_pop  = accept && (req.kind == KIND_ALLOC) && any_nonempty;

	// Next-page RAM: link index plus a valid bit in the top position. A push
	// writes the old head in its accept cycle; a pop reads it in its accept
	// cycle and consumes the data in S_POP. Only one request is in flight, so
	// a read never meets a write to the same entry in the same cycle.
	pcpa_ram #(
		.WIDTH(IDX_W + 1),
		.DEPTH(PAGE_COUNT)
	) u_next_ram (
		.clk   (clk),
		.we    (do_free),
		.waddr (page_num[IDX_W-1:0]),
		.wdata ({sel_nonempty, sel_head}),
		.re    (do_pop),
		.raddr (sel_head),
		.rdata (ram_rdata)
	);

	// Head registers carry payload only; their meaning is set by nonempty_q.
	always_ff @(posedge clk) begin
		if (do_free) begin
			heads_q[cpu_list] <= page_num[IDX_W-1:0];
		end else if (state_q == S_POP) begin
			heads_q[pop_list_q] <= ram_rdata[IDX_W-1:0];
		end
		if (do_pop) begin
			pop_list_q <= found;
			pop_idx_q  <= sel_head;
		end
	end

	// Control state and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			nonempty_q   <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_FREED;
			rsp_addr_q   <= '0;
			rsp_list_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.kind == KIND_FREE) begin
							rsp_valid_q  <= 1'b1;
							rsp_status_q <= free_ok ? ST_FREED : ST_REJECTED;
							rsp_addr_q   <= '0;
							rsp_list_q   <= '0;
							if (free_ok) begin
								nonempty_q[cpu_list] <= 1'b1;
							end
						end else if (any_nonempty) begin
							rsp_valid_q <= 1'b0;
							state_q     <= S_POP;
						end else begin
							rsp_valid_q  <= 1'b1;
							rsp_status_q <= ST_EMPTY;
							rsp_addr_q   <= '0;
							rsp_list_q   <= '0;
						end
					end else if (rsp.ready) begin
						rsp_valid_q <= 1'b0;
					end
				end
				S_POP: begin
					nonempty_q[pop_list_q] <= ram_rdata[IDX_W];
					rsp_valid_q  <= 1'b1;
					rsp_status_q <= ST_ALLOCATED;
					rsp_addr_q   <= table_base_q + (ADDR_W'(pop_idx_q) << PAGE_SHIFT);
					rsp_list_q   <= CPU_W'(pop_list_q);
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.page_address = rsp_addr_q;
	assign rsp.source_list  = rsp_list_q;

	// ------------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------------
	a_pop_enters_read: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> (state_q == S_POP) && !rsp.valid)
		else $error("allocate with a non-empty list did not enter the pop cycle");

	a_pop_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |=> rsp.valid && (rsp.status == ST_ALLOCATED))
		else $error("pop cycle did not produce an allocated response");

	a_alloc_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_ALLOCATED)
		|-> (rsp.page_address[PAGE_SHIFT-1:0] == table_base_q[PAGE_SHIFT-1:0]))
		else $error("allocated address is not on a page frame of the table");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && ((rsp.status == ST_FREED) || (rsp.status == ST_EMPTY)
			|| (rsp.status == ST_REJECTED))
		|-> (rsp.page_address == '0) && (rsp.source_list == '0))
		else $error("non-allocate response carries a page address or list");

endmodule

`default_nettype wire
